// ----- rtl/core/rcwp_pkg.sv -----
// Shared types, constants and helpers for the read-ahead cache window policy.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rcwp_pkg;

  // Field widths (fixed by the port definition)
  localparam int POS_W     = 48;
  localparam int OFF_W     = 49;
  localparam int SIZE_W    = 24;
  localparam int DONE_W    = 25;
  localparam int CHUNK_W   = 29;
  localparam int WFLUSH_W  = 29;
  localparam int TFLUSH_W  = 31;
  localparam int GRAN_W    = 17;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  // Read-ahead grows to request_size times 32
  localparam int RA_SHIFT  = 5;

  // Hint queue sizing
  localparam int MAX_HINTS = 3;
  localparam int HQ_DEPTH  = 4;
  localparam int HQ_PTR_W  = 2;
  localparam int HQ_CNT_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_RA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WFLUSH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TFLUSH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAN    = 3'd4;

  // Register reset values
  localparam logic [POS_W-1:0]    INIT_READAHEAD = 48'd131072;
  localparam logic [CHUNK_W-1:0]  CHUNK_RST      = 29'd8388608;
  localparam logic [WFLUSH_W-1:0] WFLUSH_RST     = 29'd819200;
  localparam logic [TFLUSH_W-1:0] TFLUSH_RST     = 31'd33554432;
  localparam logic [GRAN_W-1:0]   GRAN_RST       = 17'd4096;

  // Request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_SEEK  = 2'd2;

  // Hint kinds
  localparam logic HINT_DROP     = 1'b0;
  localparam logic HINT_PREFETCH = 1'b1;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [SIZE_W-1:0]       request_size;
    logic signed [DONE_W-1:0] bytes_done;
    logic [POS_W-1:0]        new_position;
  } req_t;

  typedef struct packed {
    logic                    kind;
    logic signed [OFF_W-1:0] offset;
    logic [POS_W-1:0]        length;
    logic                    last;
  } hint_t;

  // Up to three hints of one request, packed from slot 0
  typedef struct packed {
    hint_t [MAX_HINTS-1:0] slot;
    logic [1:0]            count;
  } hint_bundle_t;

  function automatic pos_t sat_add(pos_t a, pos_t b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W] ? '1 : s[POS_W-1:0];
  endfunction

  // Drop hint widened by granule minus one on each side
  function automatic hint_t drop_hint(pos_t off, pos_t len, logic [GRAN_W-1:0] gran);
    logic [GRAN_W-1:0] g;
    logic [POS_W:0]    wlen;
    hint_t             h;
    g        = (gran == '0) ? '0 : gran - 1'b1;
    wlen     = {1'b0, len} + {{(POS_W-GRAN_W){1'b0}}, g, 1'b0};
    h.kind   = HINT_DROP;
    h.offset = {1'b0, off} - {{(OFF_W-GRAN_W){1'b0}}, g};
    h.length = wlen[POS_W] ? '1 : wlen[POS_W-1:0];
    h.last   = 1'b0;
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rcwp_if.sv -----
// Valid/ready channel interfaces: request words in, hint words out.
// Depends on rcwp_pkg.
`default_nettype none

interface rcwp_req_if;
  import rcwp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [SIZE_W-1:0]        request_size;
  logic signed [DONE_W-1:0] bytes_done;
  logic [POS_W-1:0]         new_position;

  modport source (output valid, req_type, request_size, bytes_done, new_position,
                  input ready);
  modport sink   (input valid, req_type, request_size, bytes_done, new_position,
                  output ready);
endinterface

interface rcwp_hint_if;
  import rcwp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hint_kind;
  logic signed [OFF_W-1:0] hint_offset;
  logic [POS_W-1:0]        hint_length;
  logic                    last_hint;

  modport source (output valid, hint_kind, hint_offset, hint_length, last_hint,
                  input ready);
  modport sink   (input valid, hint_kind, hint_offset, hint_length, last_hint,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/readahead_cache_window_policy.sv -----
// Top level: request input register, configuration registers, policy engine, hint queue.
// Depends on rcwp_pkg, rcwp_if, rcwp_engine and rcwp_hint_fifo.
//
//  port    | dir | handshake      | word
//  in_ch   | in  | valid / ready  | req_type, request_size, bytes_done, new_position
//  out_ch  | out | valid / ready  | hint_kind, hint_offset, hint_length, last_hint
//  cfg_*   | in  | cfg_we strobe  | cfg_index, cfg_wdata
//
// A request word is registered, then processed: policy state updates and zero to three
// hint words enter a four-entry queue. The first hint leaves from that queue, which lies
// after the input register. One request per cycle is taken while the queue holds at
// most one hint; a stalled output holds the queue and then the input register.
// Synchronous active-low reset loads the read-ahead size with 128 KiB and clears all
// positions and counters.
`default_nettype none

module readahead_cache_window_policy (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rcwp_req_if.sink                             in_ch,
  rcwp_hint_if.source                          out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [rcwp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rcwp_pkg::CFG_W-1:0]      cfg_wdata
);
  import rcwp_pkg::*;

  logic                 in_vld_r;
  req_t                 req_r;
  logic                 room, go, in_acc;
  hint_bundle_t         bundle;

  logic [CHUNK_W-1:0]   chunk_r;
  logic [WFLUSH_W-1:0]  wflush_r;
  logic [TFLUSH_W-1:0]  tflush_r;
  logic [GRAN_W-1:0]    gran_r;

  assign go          = in_vld_r && room;
  assign in_ch.ready = !in_vld_r || go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= '{req_type: in_ch.req_type, request_size: in_ch.request_size,
                 bytes_done: in_ch.bytes_done, new_position: in_ch.new_position};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  // Initial read-ahead only matters at reset, so a write to it has no effect
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r  <= CHUNK_RST;
      wflush_r <= WFLUSH_RST;
      tflush_r <= TFLUSH_RST;
      gran_r   <= GRAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHUNK:  chunk_r  <= cfg_wdata[CHUNK_W-1:0];
        CFG_WFLUSH: wflush_r <= cfg_wdata[WFLUSH_W-1:0];
        CFG_TFLUSH: tflush_r <= cfg_wdata[TFLUSH_W-1:0];
        CFG_GRAN:   gran_r   <= cfg_wdata[GRAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcwp_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (go),
    .req    (req_r),
    .chunk  (chunk_r),
    .wflush (wflush_r),
    .tflush (tflush_r),
    .gran   (gran_r),
    .bundle (bundle)
  );

  rcwp_hint_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (go),
    .bundle (bundle),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/core/rcwp_engine.sv -----
// Policy state and one-pass next-state / hint computation per request word.
// Depends on rcwp_pkg.
`default_nettype none

module rcwp_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire rcwp_pkg::req_t                req,
  input  wire logic [rcwp_pkg::CHUNK_W-1:0]  chunk,
  input  wire logic [rcwp_pkg::WFLUSH_W-1:0] wflush,
  input  wire logic [rcwp_pkg::TFLUSH_W-1:0] tflush,
  input  wire logic [rcwp_pkg::GRAN_W-1:0]   gran,
  output rcwp_pkg::hint_bundle_t             bundle
);
  import rcwp_pkg::*;

  pos_t pos_r, prev_r, ws_r, we_r, pf_r, ra_r, wb_r, wsf_r, wt_r;
  pos_t pos_nxt, prev_nxt, ws_nxt, we_nxt, pf_nxt, ra_nxt, wb_nxt, wsf_nxt, wt_nxt;

  logic  done, seq, win_out, pf_need, pf_emit, trim_tail, trim_head;
  pos_t  nb, ws1, we1, ws2, pos2, we2, pf_end, pf2, we3, ra32, ra2;
  pos_t  chunk_ext, chunk2x, keep_lo, keep_hi, ws3, we4;
  hint_t hint_win, hint_pf, hint_trim;

  logic  flush, wdrop, wide, pos_gt;
  pos_t  wb1, wpos, wsf2, wprev, wf2, hd, wt2;
  logic [POS_W+1:0] t3;
  hint_t hint_wr, hint_wide;

  logic  va, vb, vc;
  hint_t ca, cb, cc;
  logic [1:0] n;

  // Read path
  always_comb begin
    done      = !req.bytes_done[DONE_W-1] && (req.bytes_done != '0);
    nb        = {{(POS_W-DONE_W+1){1'b0}}, req.bytes_done[DONE_W-2:0]};
    seq       = (pos_r >= prev_r) && ((pos_r - prev_r) <= ra_r);
    win_out   = (ws_r < we_r) && ((pos_r < ws_r) || (pos_r > we_r));
    ws1       = win_out ? pos_r : ws_r;
    we1       = win_out ? pos_r : we_r;
    ws2       = (pos_r < ws1) ? pos_r : ws1;
    pos2      = done ? sat_add(pos_r, nb) : pos_r;
    we2       = (done && (we1 < pos2)) ? pos2 : we1;
    pf_need   = (pf_r < pos2) || ((pf_r - pos2) < (ra_r >> 1));
    pf_emit   = done && seq && pf_need;
    pf_end    = sat_add(pos2, ra_r);
    if (!done) begin
      pf2 = pf_r;
    end else if (seq) begin
      pf2 = pf_need ? pf_end : pf_r;
    end else begin
      pf2 = pos2;
    end
    we3       = (pf_emit && (we2 < pf_end)) ? pf_end : we2;
    ra32      = {{(POS_W-SIZE_W-RA_SHIFT){1'b0}}, req.request_size, {RA_SHIFT{1'b0}}};
    ra2       = (done && seq && (ra_r < ra32)) ? ra32 : ra_r;
    chunk_ext = {{(POS_W-CHUNK_W){1'b0}}, chunk};
    chunk2x   = {{(POS_W-CHUNK_W-1){1'b0}}, chunk, 1'b0};
    keep_lo   = pos2 - chunk_ext;
    keep_hi   = pos2 + chunk_ext;
    trim_tail = (ws2 < we3) && (pos2 > ws2) && ((pos2 - ws2) > chunk2x);
    trim_head = (ws2 < we3) && !trim_tail && (we3 > pf2) && (we3 > pos2) &&
                ((we3 - pos2) > chunk2x);
    ws3       = trim_tail ? keep_lo : ws2;
    we4       = trim_head ? keep_hi : we3;

    hint_win  = drop_hint(ws_r, we_r - ws_r, gran);
    hint_pf   = '{kind: HINT_PREFETCH, offset: {1'b0, pos2}, length: ra_r, last: 1'b0};
    hint_trim = trim_tail ? drop_hint(ws2, keep_lo - ws2, gran)
                          : drop_hint(keep_hi, we3 - keep_hi, gran);
  end

  // Write path
  always_comb begin
    wb1    = (pos_r < wb_r) ? pos_r : wb_r;
    wpos   = sat_add(pos_r, nb);
    wsf2   = sat_add(wsf_r, nb);
    wprev  = (prev_r < wpos) ? wpos : prev_r;
    flush  = wsf2 > {{(POS_W-WFLUSH_W){1'b0}}, wflush};
    wdrop  = flush && (wprev > wb1);
    wf2    = {{(POS_W-WFLUSH_W-1){1'b0}}, wflush, 1'b0};
    hd     = (wb1 < wf2) ? wb1 : wf2;
    wt2    = sat_add(wt_r, wsf2);
    wide   = flush && (wt2 > {{(POS_W-TFLUSH_W){1'b0}}, tflush});
    t3     = {2'b00, wt2} + {1'b0, wt2, 1'b0};
    pos_gt = {2'b00, wpos} > t3;

    hint_wr = '{kind: HINT_DROP, offset: {1'b0, wb1 - hd}, length: wprev - wb1 + hd,
                last: 1'b0};
    if (pos_gt) begin
      hint_wide = '{kind: HINT_DROP, offset: {1'b0, wpos - t3[POS_W-1:0]},
                    length: t3[POS_W-1:0], last: 1'b0};
    end else begin
      hint_wide = '{kind: HINT_DROP, offset: '0, length: wpos, last: 1'b0};
    end
  end

  // Next state and hint candidates
  always_comb begin
    pos_nxt = pos_r;  prev_nxt = prev_r; ws_nxt = ws_r;  we_nxt = we_r;
    pf_nxt  = pf_r;   ra_nxt   = ra_r;   wb_nxt = wb_r;  wsf_nxt = wsf_r;
    wt_nxt  = wt_r;
    va = 1'b0; vb = 1'b0; vc = 1'b0;
    ca = hint_win; cb = hint_pf; cc = hint_trim;
    unique case (req.req_type)
      REQ_READ: begin
        pos_nxt  = pos2;
        prev_nxt = pos2;
        ws_nxt   = ws3;
        we_nxt   = we4;
        pf_nxt   = pf2;
        ra_nxt   = ra2;
        va       = win_out;
        vb       = pf_emit;
        vc       = trim_tail || trim_head;
      end
      REQ_WRITE: begin
        ca = hint_wr;
        cb = hint_wide;
        if (done) begin
          pos_nxt  = wpos;
          wb_nxt   = flush ? wpos : wb1;
          prev_nxt = flush ? wpos : wprev;
          wsf_nxt  = flush ? '0 : wsf2;
          wt_nxt   = flush ? (wide ? '0 : wt2) : wt_r;
          va       = wdrop;
          vb       = wide;
        end
      end
      REQ_SEEK: begin
        pos_nxt = req.new_position;
      end
      default: begin
      end
    endcase
  end

  // Pack valid candidates from slot 0 and flag the final one
  always_comb begin
    n = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
    bundle.count   = n;
    bundle.slot[0] = va ? ca : (vb ? cb : cc);
    bundle.slot[1] = (va && vb) ? cb : cc;
    bundle.slot[2] = cc;
    bundle.slot[0].last = (n == 2'd1);
    bundle.slot[1].last = (n == 2'd2);
    bundle.slot[2].last = (n == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0; prev_r <= '0; ws_r  <= '0; we_r <= '0; pf_r <= '0;
      ra_r   <= INIT_READAHEAD;
      wb_r   <= '0; wsf_r  <= '0; wt_r  <= '0;
    end else if (fire) begin
      pos_r  <= pos_nxt; prev_r <= prev_nxt; ws_r <= ws_nxt; we_r <= we_nxt;
      pf_r   <= pf_nxt;  ra_r   <= ra_nxt;
      wb_r   <= wb_nxt;  wsf_r  <= wsf_nxt;  wt_r <= wt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rcwp_hint_fifo.sv -----
// Four-entry hint queue: takes up to three hint words at once, sends one per cycle while out_ch is ready.
// Depends on rcwp_pkg and rcwp_hint_if.
`default_nettype none

module rcwp_hint_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire rcwp_pkg::hint_bundle_t bundle,
  output logic                        room,
  rcwp_hint_if.source                 out_ch
);
  import rcwp_pkg::*;

  hint_t               q_r [HQ_DEPTH];
  logic [HQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [HQ_CNT_W-1:0] cnt_r, cnt_nxt, n_push;
  logic                pop;
  hint_t               head;

  assign n_push = push ? {{(HQ_CNT_W-2){1'b0}}, bundle.count} : '0;
  assign pop    = out_ch.valid && out_ch.ready;
  assign cnt_nxt = cnt_r + n_push - {{(HQ_CNT_W-1){1'b0}}, pop};
  // Room for a full set of hints from the next request
  assign room   = cnt_r <= HQ_CNT_W'(HQ_DEPTH - MAX_HINTS);

  assign head               = q_r[rd_ptr_r];
  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.hint_kind   = head.kind;
  assign out_ch.hint_offset = head.offset;
  assign out_ch.hint_length = head.length;
  assign out_ch.last_hint   = head.last;

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_HINTS; k++) begin
      if (push && (k < int'(bundle.count))) begin
        q_r[wr_ptr_r + HQ_PTR_W'(k)] <= bundle.slot[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push[HQ_PTR_W-1:0];
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sim/rcwp_hint_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the read-ahead window policy. It mirrors the policy state and predicts
// the hint words of each request word, then compares them with what the block sends.
// Needs rcwp_pkg and the channel interfaces in rcwp_if.
module rcwp_hint_checker
  import rcwp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  rcwp_req_if                  req_mon,
  rcwp_hint_if                 hint_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   outstanding,
  output int                   hints_seen
);

  localparam logic [63:0] POS_LIMIT = (64'd1 << POS_W) - 1;

  // register mirror
  logic [63:0] init_ra, chunk, wflush, tflush, granule;
  // policy state
  logic [63:0] pos, prev_pos, win_start, win_end, fetched_to, ra_size;
  logic [63:0] wr_begin, wr_pending, wr_total;

  hint_t expected_hints[$];
  int    errors = 0;
  int    seen = 0;

  function automatic logic [63:0] clamp_sum(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > POS_LIMIT) ? POS_LIMIT : s;
  endfunction

  task automatic add_hint(input logic kind, input logic [63:0] off_pos,
                          input logic [63:0] off_neg, input logic [63:0] len);
    hint_t       h;
    logic [63:0] off;
    off      = off_pos - off_neg;
    h.kind   = kind;
    h.offset = off[OFF_W-1:0];
    h.length = (len > POS_LIMIT) ? POS_LIMIT[POS_W-1:0] : len[POS_W-1:0];
    h.last   = 1'b0;
    expected_hints.push_back(h);
  endtask

  // widen by granule minus one on each side
  task automatic add_drop(input logic [63:0] off, input logic [63:0] len);
    logic [63:0] g;
    g = (granule == 0) ? 64'd0 : granule - 1;
    add_hint(HINT_DROP, off, g, len + 2 * g);
  endtask

  task automatic read_access(input logic [63:0] size, input logic did,
                             input logic [63:0] nbytes);
    logic        seq;
    logic [63:0] head;
    seq = (pos >= prev_pos) && (pos - prev_pos <= ra_size);
    if (win_start < win_end && (pos < win_start || pos > win_end)) begin
      add_drop(win_start, win_end - win_start);
      win_start = pos;
      win_end   = pos;
    end
    if (pos < win_start)
      win_start = pos;
    if (did) begin
      pos = clamp_sum(pos, nbytes);
      if (win_end < pos)
        win_end = pos;
      if (seq) begin
        if (fetched_to < pos || fetched_to - pos < (ra_size >> 1)) begin
          add_hint(HINT_PREFETCH, pos, 64'd0, ra_size);
          fetched_to = clamp_sum(pos, ra_size);
          if (win_end < fetched_to)
            win_end = fetched_to;
        end
        if (ra_size < (size << RA_SHIFT))
          ra_size = ((size << RA_SHIFT) > POS_LIMIT) ? POS_LIMIT : (size << RA_SHIFT);
      end else begin
        fetched_to = pos;
      end
    end
    if (win_start < win_end) begin
      if (pos > win_start && pos - win_start > 2 * chunk) begin
        add_drop(win_start, pos - chunk - win_start);
        win_start = pos - chunk;
      end else if (win_end > fetched_to && win_end > pos && win_end - pos > 2 * chunk) begin
        head = pos + chunk;
        add_drop(head, win_end - head);
        win_end = head;
      end
    end
    prev_pos = pos;
  endtask

  task automatic write_access(input logic [63:0] nbytes);
    logic [63:0] hd, t3;
    if (pos < wr_begin)
      wr_begin = pos;
    pos        = clamp_sum(pos, nbytes);
    wr_pending = clamp_sum(wr_pending, nbytes);
    if (prev_pos < pos)
      prev_pos = pos;
    if (wr_pending > wflush) begin
      if (prev_pos > wr_begin) begin
        hd = 2 * wflush;
        if (wr_begin < hd)
          hd = wr_begin;
        add_hint(HINT_DROP, wr_begin - hd, 64'd0, prev_pos - wr_begin + hd);
      end
      wr_begin   = pos;
      prev_pos   = pos;
      wr_total   = clamp_sum(wr_total, wr_pending);
      wr_pending = 0;
      if (wr_total > tflush) begin
        t3 = 3 * wr_total;
        // clip the wide drop at offset zero
        if (pos > t3)
          add_hint(HINT_DROP, pos - t3, 64'd0, t3);
        else
          add_hint(HINT_DROP, 64'd0, 64'd0, pos);
        wr_total = 0;
      end
    end
  endtask

  task automatic apply_request();
    logic [1:0]        kind;
    logic [DONE_W-1:0] raw;
    logic              did;
    int                n_prior;
    hint_t             h;
    kind    = req_mon.req_type;
    raw     = req_mon.bytes_done;
    did     = !raw[DONE_W-1] && raw != '0;
    n_prior = expected_hints.size();
    case (kind)
      REQ_READ:  read_access(64'(req_mon.request_size), did, 64'(raw));
      REQ_WRITE: if (did) write_access(64'(raw));
      REQ_SEEK:  pos = 64'(req_mon.new_position);
      default:   ;
    endcase
    // flag the final hint of this word
    if (expected_hints.size() > n_prior) begin
      h      = expected_hints.pop_back();
      h.last = 1'b1;
      expected_hints.push_back(h);
    end
  endtask

  task automatic check_hint();
    hint_t got, want;
    got.kind   = hint_mon.hint_kind;
    got.offset = hint_mon.hint_offset;
    got.length = hint_mon.hint_length;
    got.last   = hint_mon.last_hint;
    seen++;
    if (expected_hints.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected hint: kind %0d offset %0d length %0d last %0d",
                 got.kind, got.offset, got.length, got.last);
    end else begin
      want = expected_hints.pop_front();
      if (got.kind !== want.kind || got.offset !== want.offset ||
          got.length !== want.length || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"hint mismatch: expected kind %0d offset %0d length %0d last %0d,",
                    " got kind %0d offset %0d length %0d last %0d"},
                   want.kind, want.offset, want.length, want.last,
                   got.kind, got.offset, got.length, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      init_ra    = 64'(INIT_READAHEAD);
      chunk      = 64'(CHUNK_RST);
      wflush     = 64'(WFLUSH_RST);
      tflush     = 64'(TFLUSH_RST);
      granule    = 64'(GRAN_RST);
      pos        = 0;
      prev_pos   = 0;
      win_start  = 0;
      win_end    = 0;
      fetched_to = 0;
      ra_size    = init_ra;
      wr_begin   = 0;
      wr_pending = 0;
      wr_total   = 0;
      expected_hints.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INIT_RA: init_ra = 64'(cfg_wdata[24:0]);
          CFG_CHUNK:   chunk   = 64'(cfg_wdata[CHUNK_W-1:0]);
          CFG_WFLUSH:  wflush  = 64'(cfg_wdata[WFLUSH_W-1:0]);
          CFG_TFLUSH:  tflush  = 64'(cfg_wdata[TFLUSH_W-1:0]);
          CFG_GRAN:    granule = 64'(cfg_wdata[GRAN_W-1:0]);
          default:     ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        apply_request();
      if (hint_mon.valid && hint_mon.ready)
        check_hint();
    end
    fail_count  <= errors;
    outstanding <= expected_hints.size();
    hints_seen  <= seen;
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the read-ahead window policy bench: clock, reset, request words, register writes
// and output back-pressure. Needs rcwp_pkg, rcwp_if, the block and rcwp_hint_checker.
module tb_top;
  import rcwp_pkg::*;

  localparam logic [63:0]       POS_LIMIT   = (64'd1 << POS_W) - 1;
  localparam logic [1:0]        REQ_UNKNOWN = 2'd3;
  localparam logic [DONE_W-1:0] DONE_NONE   = '1;
  localparam logic [DONE_W-1:0] DONE_FULL   = {1'b0, {SIZE_W{1'b1}}};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_len = 0;
  logic [63:0] cursor = 0;
  logic [63:0] chunk_now = 64'(CHUNK_RST);
  int          n_read = 0, n_write = 0, n_seek = 0, n_ignored = 0;
  int          fail_count, outstanding, hints_seen;

  rcwp_req_if  req_ch ();
  rcwp_hint_if hint_ch ();

  readahead_cache_window_policy DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (hint_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rcwp_hint_checker u_hint_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_ch),
    .hint_mon    (hint_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .hints_seen  (hints_seen)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or a long hold-off counted down here
  initial begin
    hint_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        hint_ch.ready <= 1'b0;
        hold_len--;
      end else begin
        hint_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL readahead_cache_window_policy");
    $finish;
  end

  task automatic send_req(input logic [1:0] kind, input logic [SIZE_W-1:0] size,
                          input logic [DONE_W-1:0] done, input logic [POS_W-1:0] np);
    logic [63:0] n;
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.request_size <= size;
    req_ch.bytes_done   <= done;
    req_ch.new_position <= np;
    do @(posedge clk); while (!req_ch.ready);
    n = 64'(done);
    case (kind)
      REQ_READ, REQ_WRITE: begin
        if (!done[DONE_W-1] && done != '0)
          cursor = (cursor + n > POS_LIMIT) ? POS_LIMIT : cursor + n;
        if (kind == REQ_READ)
          n_read++;
        else
          n_write++;
      end
      REQ_SEEK: begin
        cursor = 64'(np);
        n_seek++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic send_random(output bit counted);
    logic [1:0]        kind;
    logic [SIZE_W-1:0] size;
    logic [DONE_W-1:0] done;
    logic [63:0]       np, back;
    int                roll;
    roll = $urandom_range(99);
    if (roll < 50)
      size = SIZE_W'($urandom_range(1, 65536));
    else if (roll < 75)
      size = SIZE_W'($urandom_range(65536, 1 << 20));
    else if (roll < 88)
      size = SIZE_W'($urandom_range(1 << 20, (1 << 24) - 1));
    else if (roll < 94)
      size = '0;
    else
      size = '1;
    roll = $urandom_range(99);
    if (roll < 70)
      done = {1'b0, size};
    else if (roll < 80)
      done = DONE_W'($urandom_range(0, size));
    else if (roll < 87)
      done = '0;
    else if (roll < 94)
      done = DONE_NONE;
    else
      done = DONE_W'($urandom);
    // seek target: mostly near the current position, some far or at the top
    roll = $urandom_range(99);
    if (roll < 35) begin
      back = chunk_now * 64'($urandom_range(0, 4)) + 64'($urandom_range(0, 1 << 16));
      np   = (cursor > back) ? cursor - back : 64'd0;
    end else if (roll < 60) begin
      np = cursor + 64'($urandom_range(0, 1 << 20));
      if (np > POS_LIMIT)
        np = POS_LIMIT;
    end else if (roll < 72) begin
      np = cursor;
    end else if (roll < 86) begin
      np = 64'($urandom_range(0, 1 << 26));
    end else if (roll < 95) begin
      np = POS_LIMIT - 64'($urandom_range(0, 1 << 24));
    end else begin
      np = {$urandom, $urandom};
    end
    roll = $urandom_range(99);
    if (roll < 42)
      kind = REQ_READ;
    else if (roll < 67)
      kind = REQ_WRITE;
    else if (roll < 89)
      kind = REQ_SEEK;
    else if (roll < 92)
      kind = REQ_UNKNOWN;
    else begin
      // noise word
      kind = 2'($urandom_range(3));
      size = SIZE_W'($urandom);
      done = DONE_W'($urandom);
      np   = {$urandom, $urandom};
    end
    send_req(kind, size, done, np[POS_W-1:0]);
    counted = (kind != REQ_UNKNOWN);
  endtask

  // Hold input until every hint is out and the pipeline is empty
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count, input int hold,
                           input logic [CFG_W-1:0] ra0, input logic [CFG_W-1:0] ch,
                           input logic [CFG_W-1:0] wf, input logic [CFG_W-1:0] tf,
                           input logic [CFG_W-1:0] gr);
    int sent;
    bit counted;
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INIT_RA;
    cfg_wdata <= ra0;
    @(posedge clk);
    cfg_index <= CFG_CHUNK;
    cfg_wdata <= ch;
    @(posedge clk);
    cfg_index <= CFG_WFLUSH;
    cfg_wdata <= wf;
    @(posedge clk);
    cfg_index <= CFG_TFLUSH;
    cfg_wdata <= tf;
    @(posedge clk);
    cfg_index <= CFG_GRAN;
    cfg_wdata <= gr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    chunk_now = 64'(ch);
    idle_pct  = idle;
    stall_pct = stall;
    hold_len  = hold;
    sent      = 0;
    while (sent < count) begin
      send_random(counted);
      if (counted)
        sent++;
    end
  endtask

  initial begin
    int w;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= '0;
    req_ch.request_size <= '0;
    req_ch.bytes_done   <= '0;
    req_ch.new_position <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset settings
    send_req(REQ_READ, 24'd4096, 25'd4096, '0);
    send_req(REQ_READ, 24'd65536, 25'd65536, '0);
    send_req(REQ_READ, '1, DONE_FULL, '0);
    send_req(REQ_READ, '0, '0, '0);
    send_req(REQ_READ, 24'd4096, DONE_NONE, '0);
    send_req(REQ_WRITE, 24'd1, 25'd1, '0);
    send_req(REQ_WRITE, 24'd100, '0, '0);
    send_req(REQ_WRITE, 24'd100, DONE_NONE, '0);
    // write-range drops, then a wide drop clipped at zero
    repeat (3) send_req(REQ_WRITE, '1, DONE_FULL, '0);
    send_req(REQ_SEEK, '0, '0, cursor[POS_W-1:0]);
    send_req(REQ_UNKNOWN, '1, DONE_NONE, '1);
    // window drop below offset zero, then saturate at the top
    send_req(REQ_SEEK, '0, '0, POS_LIMIT[POS_W-1:0] - 48'd100);
    send_req(REQ_READ, '1, DONE_FULL, '0);
    send_req(REQ_WRITE, '1, DONE_FULL, '0);
    send_req(REQ_SEEK, '0, '0, '0);
    send_req(REQ_READ, 24'd8192, 25'd8192, '0);
    send_req(REQ_SEEK, '0, '0, 48'h5555_5555_5555);
    send_req(REQ_READ, 24'hAA_AAAA, 25'h055_5555, 48'hAAAA_AAAA_AAAA);
    send_req(REQ_SEEK, '0, '0, 48'hAAAA_AAAA_AAAA);
    send_req(REQ_WRITE, 24'h55_5555, 25'h0AA_AAAA, '0);
    send_req(REQ_READ, 24'd4096, 25'h155_5555, '0);

    run_phase(0, 0, 64, 64, 31'd0, 31'd65536, 31'd1, 31'd1, 31'd1);
    run_phase(58, 0, 64, 0, 31'd16777216, 31'd268435456, 31'd268435456, 31'd1073741824,
              31'd65536);
    run_phase(0, 58, 64, 0, 31'd4096, 31'd1048576, 31'd262144, 31'd4194304, 31'd0);
    run_phase(18, 18, 64, 0, 31'd131072, 31'd1, 31'd4096, 31'd1048576, 31'd131071);

    req_ch.valid <= 1'b0;
    for (w = 0; w < 20000 && outstanding != 0; w++)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d reads, %0d writes, %0d seeks and %0d unknown requests",
             n_read, n_write, n_seek, n_ignored);
    $display("%0d hints compared over five register settings and four idle/stall mixes",
             hints_seen);
    if (outstanding != 0)
      $display("%0d expected hints never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS readahead_cache_window_policy");
    else
      $display("FAIL readahead_cache_window_policy");
    $finish;
  end

endmodule
